FILE: src/pct_pkg.sv
// Shared types and constants for the position cluster table.
`timescale 1ns / 1ps

package pct_pkg;

   localparam int POS_W      = 24;
   localparam int CNT_W      = 16;
   localparam int WIN_W      = 16;
   localparam int MAXE_W     = 5;
   localparam int SLOT_W     = 4;
   localparam int HELD_W     = 5;
   localparam int PROD_W     = POS_W + CNT_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int DIVR_W     = CNT_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE      = 2'd0,
      CSR_WINDOW      = 2'd1,
      CSR_MAX_ENTRIES = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_APPEND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0] centre;
      logic [CNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic              updated;
      logic              merged;
      logic              evicted;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  centre;
      logic [CNT_W-1:0]  count;
      logic [HELD_W-1:0] held;
   } result_type;

endpackage

FILE: src/position_cluster_table_core.sv
// Top level of the position cluster table: sequencer, registers and stream ports.
`timescale 1ns / 1ps

// Leader clustering over event positions (unsigned Q20.4). Each accepted
// event is compared with the stored cluster centres from the oldest entry on,
// one entry at a time through the single read port of the entry
// memory. The first centre within merge_window*16 absorbs the event through a
// running mean that a serial divider computes at one quotient bit per cycle;
// otherwise the event is appended, dropping the oldest entry when the table
// is full. The table is a ring in memory, so dropping the oldest entry only
// moves the head pointer. One event is processed at a time, and a finished
// result waits in the output register while the next event is taken.
// Configuration writes are always accepted and must only be made while no
// event is in flight.

module position_cluster_table_core #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: event_position [23:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pct_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: slot [3:0], centre_position [27:4], hit_count [43:28],
   // entries_held [48:44], zero fill above
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pct_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: updated [0], merged [1], evicted [2]
   output logic [pct_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pct_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pct_pkg::WIN_W-1:0]          csr_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W = $clog2(DEPTH + 1);

   pct_pkg::state_type             state_ff, state_in;
   logic                           enable_ff;
   logic [pct_pkg::WIN_W-1:0]      window_ff;
   logic [pct_pkg::MAXE_W-1:0]     max_ff;
   logic [pct_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [PTR_W-1:0]               idx_ff, idx_in;
   logic [PTR_W-1:0]               ptr_ff, ptr_in;
   logic [PTR_W-1:0]               head_ff, head_in;
   logic [PTR_W-1:0]               tail_ff, tail_in;
   logic [OCC_W-1:0]               occ_ff, occ_in;
   logic [pct_pkg::POS_W-1:0]      centre_ff, centre_in;
   logic [pct_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [pct_pkg::PROD_W-1:0]     prod_ff, prod_in;
   pct_pkg::result_type            res_ff, res_in;
   pct_pkg::result_type            out_ff, out_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic                           mem_we;
   logic [PTR_W-1:0]               mem_waddr;
   pct_pkg::entry_type             mem_wdata;
   pct_pkg::entry_type             mem_rdata;
   logic                           div_start;
   logic [pct_pkg::SUM_W-1:0]      div_dividend;
   logic [pct_pkg::DIVR_W-1:0]     div_divisor;
   logic                           div_done;
   logic [pct_pkg::POS_W-1:0]      div_quotient;

   logic [pct_pkg::POS_W-1:0]      distance;
   logic [pct_pkg::POS_W-1:0]      limit;
   logic [pct_pkg::CNT_W-1:0]      next_count;
   logic                           evict;
   logic [OCC_W-1:0]               slot_pos;
   logic                           out_free;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   pct_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (PTR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (ptr_ff),
      .rd_data (mem_rdata)
   );

   pct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_tready = (state_ff == pct_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign distance = (mem_rdata.centre >= pos_ff) ? mem_rdata.centre - pos_ff
                                                  : pos_ff - mem_rdata.centre;
   assign limit = {4'b0000, window_ff, 4'b0000};
   assign next_count = (count_ff == pct_pkg::CNT_MAX) ? count_ff : count_ff + 1'b1;
   assign evict = (occ_ff != '0) &&
                  ((32'(occ_ff) >= 32'(max_ff)) || (32'(occ_ff) >= DEPTH));
   assign slot_pos = evict ? occ_ff - 1'b1 : occ_ff;

   assign div_dividend = {1'b0, prod_ff} + pct_pkg::SUM_W'(pos_ff);
   assign div_divisor  = {1'b0, count_ff} + 1'b1;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      centre_in    = centre_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_waddr    = tail_ff;
      mem_wdata    = '{centre: pos_ff, count: pct_pkg::CNT_W'(1)};
      div_start    = 1'b0;

      unique case (state_ff)
         pct_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               pos_in = req_tdata[pct_pkg::POS_W-1:0];
               idx_in = '0;
               ptr_in = head_ff;
               if (!enable_ff) begin
                  res_in      = '0;
                  res_in.held = pct_pkg::HELD_W'(occ_ff);
                  state_in    = pct_pkg::ST_OUT;
               end else if (occ_ff == '0) begin
                  state_in = pct_pkg::ST_APPEND;
               end else begin
                  state_in = pct_pkg::ST_READ;
               end
            end
         end
         pct_pkg::ST_READ: begin
            state_in = pct_pkg::ST_CMP;
         end
         pct_pkg::ST_CMP: begin
            if (distance <= limit) begin
               centre_in = mem_rdata.centre;
               count_in  = mem_rdata.count;
               state_in  = pct_pkg::ST_MUL;
            end else if (OCC_W'(idx_ff) + 1'b1 == occ_ff) begin
               state_in = pct_pkg::ST_APPEND;
            end else begin
               idx_in   = idx_ff + 1'b1;
               ptr_in   = ring_next(ptr_ff);
               state_in = pct_pkg::ST_READ;
            end
         end
         pct_pkg::ST_MUL: begin
            prod_in  = centre_ff * count_ff;
            state_in = pct_pkg::ST_DIV_START;
         end
         pct_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = pct_pkg::ST_DIV_WAIT;
         end
         pct_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff;
               mem_wdata = '{centre: div_quotient, count: next_count};
               res_in    = '{updated: 1'b1, merged: 1'b1, evicted: 1'b0,
                             slot: pct_pkg::SLOT_W'(idx_ff), centre: div_quotient,
                             count: next_count, held: pct_pkg::HELD_W'(occ_ff)};
               state_in  = pct_pkg::ST_OUT;
            end
         end
         pct_pkg::ST_APPEND: begin
            // With a full ring the tail equals the head, so the new entry
            // lands on the storage of the entry being dropped.
            mem_we  = 1'b1;
            tail_in = ring_next(tail_ff);
            if (evict) begin
               head_in = ring_next(head_ff);
            end else begin
               occ_in = occ_ff + 1'b1;
            end
            res_in   = '{updated: 1'b1, merged: 1'b0, evicted: evict,
                         slot: pct_pkg::SLOT_W'(slot_pos), centre: pos_ff,
                         count: pct_pkg::CNT_W'(1), held: pct_pkg::HELD_W'(occ_in)};
            state_in = pct_pkg::ST_OUT;
         end
         pct_pkg::ST_OUT: begin
            if (out_free) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = pct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pct_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      ptr_ff    <= ptr_in;
      centre_ff <= centre_in;
      count_ff  <= count_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         window_ff <= pct_pkg::WIN_W'(8);
         max_ff    <= pct_pkg::MAXE_W'(16);
      end else if (csr_valid) begin
         unique case (csr_index)
            pct_pkg::CSR_ENABLE:      enable_ff <= csr_data[0];
            pct_pkg::CSR_WINDOW:      window_ff <= csr_data;
            pct_pkg::CSR_MAX_ENTRIES: max_ff    <= csr_data[pct_pkg::MAXE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {out_ff.evicted, out_ff.merged, out_ff.updated};
   assign rsp_tdata  = {7'b0000000, out_ff.held, out_ff.count, out_ff.centre, out_ff.slot};

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= DEPTH)
      else $error("occupancy exceeds table depth");

   a_occ_only_on_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pct_pkg::ST_APPEND) |=> $stable(occ_ff))
      else $error("occupancy changed outside an append");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == pct_pkg::ST_DIV_WAIT))
      else $error("divider finished while not awaited");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pct_pkg::ST_OUT && out_free) |=> (rsp_tvalid && req_tready))
      else $error("result not presented after completion");
`endif

endmodule

FILE: src/pct_mem.sv
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module pct_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pct_pkg::entry_type  wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output pct_pkg::entry_type  rd_data
);

   pct_pkg::entry_type mem_ff [DEPTH];
   pct_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pct_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module pct_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pct_pkg::SUM_W-1:0]   dividend,
   input  logic [pct_pkg::DIVR_W-1:0]  divisor,
   output logic                        done,
   output logic [pct_pkg::POS_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(pct_pkg::POS_W);
   localparam int REM_W  = pct_pkg::DIVR_W;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [pct_pkg::POS_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]           divr_ff, divr_in;
   logic [REM_W:0]             trial;
   logic [REM_W:0]             diff;
   logic                       fits;

   // The quotient is known to fit the position width, so the upper dividend
   // bits already sit below the divisor and seed the remainder directly.
   always_comb begin
      trial    = {rem_ff, quo_ff[pct_pkg::POS_W-1]};
      diff     = trial - {1'b0, divr_ff};
      fits     = trial >= {1'b0, divr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      divr_in  = divr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[pct_pkg::SUM_W-1:pct_pkg::POS_W];
         quo_in  = dividend[pct_pkg::POS_W-1:0];
         divr_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         quo_in  = {quo_ff[pct_pkg::POS_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(pct_pkg::POS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      divr_ff <= divr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
